/* rtl/core/dfp_pkg.sv */
// types, constants and codes shared by the datagram fragment planner
package dfp_pkg;

    localparam int MAX_FRAGMENTS = 64;
    localparam int MF_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] LINK_MTU_RESET = 16'd1500;
    localparam logic [15:0] MIN_PIECE = 16'd8;

    localparam logic [1:0] STATUS_FRAGMENT = 2'd0;
    localparam logic [1:0] STATUS_NOT_PERMITTED = 2'd1;
    localparam logic [1:0] STATUS_SPACE_LOW = 2'd2;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd3;

    typedef struct packed {
        logic [15:0] datagram_length;
        logic [7:0]  header_length;
        logic        seg_permitted;
        logic        skip_checksum;
    } dfp_in_t;

    typedef struct packed {
        logic [15:0] datagram_id;
        logic [15:0] payload_offset;
        logic [15:0] fragment_size;
        logic [15:0] segment_length;
        logic        more_segments;
        logic        zero_checksum;
        logic [1:0]  status;
        logic        last;
    } dfp_out_t;

    // one classified datagram handed from front to back
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] left;
        logic [15:0] space;
        logic [7:0]  hlen;
        logic        zck;
    } dfp_job_t;

endpackage

/* rtl/core/dfp_front.sv */
// front end: accepts descriptors, assigns ids and classifies each datagram
module dfp_front import dfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dfp_in_t     s_data,
    input  logic [15:0] link_mtu,
    output logic        push_valid,
    input  logic        push_ready,
    output dfp_job_t    push_job
);

    logic        st_valid_reg, st_valid_next;
    logic        st_empty_reg;
    logic [1:0]  st_status_reg;
    logic [15:0] st_id_reg;
    logic [15:0] st_left_reg;
    logic [15:0] st_space_reg;
    logic [7:0]  st_hlen_reg;
    logic        st_zck_reg;
    logic [15:0] id_counter_reg, id_counter_next;

    logic               accept;
    logic               st_done;
    logic               drop;
    logic               small_space;
    logic               too_many;
    logic [16+MF_W-1:0] limit;

    assign drop = st_empty_reg;
    assign push_valid = st_valid_reg && !drop;
    assign st_done = st_valid_reg && (drop || push_ready);
    assign s_ready = !st_valid_reg || st_done;
    assign accept = s_valid && s_ready;

    // header plus the minimum piece must fit into the mtu
    assign small_space = ({1'b0, 8'd0, s_data.header_length} + {1'b0, MIN_PIECE})
                         > {1'b0, link_mtu};

    // more than the allowed pieces exactly when the payload exceeds max * space
    assign limit = (16+MF_W)'(MAX_FRAGMENTS) * (16+MF_W)'(st_space_reg);
    assign too_many = (st_status_reg == STATUS_FRAGMENT)
                      && ((16+MF_W)'(st_left_reg) > limit);

    always_comb begin
        push_job.status = too_many ? STATUS_TOO_MANY : st_status_reg;
        push_job.id = st_id_reg;
        push_job.left = st_left_reg;
        push_job.space = st_space_reg;
        push_job.hlen = st_hlen_reg;
        push_job.zck = st_zck_reg;
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        id_counter_next = id_counter_reg;
        if (st_done) begin
            st_valid_next = 1'b0;
        end
        if (accept) begin
            st_valid_next = 1'b1;
            if (s_data.seg_permitted) begin
                id_counter_next = id_counter_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            id_counter_reg <= 16'd0;
        end else begin
            st_valid_reg <= st_valid_next;
            id_counter_reg <= id_counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_empty_reg <= s_data.seg_permitted
                            && (s_data.datagram_length <= {8'd0, s_data.header_length});
            if (!s_data.seg_permitted) begin
                st_status_reg <= STATUS_NOT_PERMITTED;
            end else if (small_space) begin
                st_status_reg <= STATUS_SPACE_LOW;
            end else begin
                st_status_reg <= STATUS_FRAGMENT;
            end
            st_id_reg <= s_data.seg_permitted ? id_counter_reg : 16'd0;
            st_left_reg <= s_data.datagram_length - {8'd0, s_data.header_length};
            st_space_reg <= link_mtu - {8'd0, s_data.header_length};
            st_hlen_reg <= s_data.header_length;
            st_zck_reg <= s_data.skip_checksum;
        end
    end

endmodule

/* rtl/core/dfp_queue.sv */
// short job queue between the front and back ends
module dfp_queue import dfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  dfp_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output dfp_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dfp_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/dfp_back.sv */
// back end: walks a job one fragment per cycle into the output register while it is empty or taken
module dfp_back import dfp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  dfp_job_t pop_job,
    output logic     m_valid,
    input  logic     m_ready,
    output dfp_out_t m_data
);

    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;
    dfp_job_t    job_reg;
    logic [15:0] left_reg;
    logic [15:0] off_reg;
    dfp_out_t    out_reg;

    logic        emit;
    logic        fin;
    logic [15:0] over;
    logic [15:0] fs;
    dfp_out_t    result;

    assign pop_ready = !busy_reg;
    assign emit = busy_reg && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    // a tail under the minimum piece is grown to exactly the minimum
    assign fin = (left_reg <= job_reg.space);
    assign over = left_reg - job_reg.space;
    always_comb begin
        if (fin) begin
            fs = left_reg;
        end else if (over < MIN_PIECE) begin
            fs = left_reg - MIN_PIECE;
        end else begin
            fs = job_reg.space;
        end
    end

    always_comb begin
        result = '0;
        result.datagram_id = job_reg.id;
        result.status = job_reg.status;
        result.last = 1'b1;
        if (job_reg.status == STATUS_FRAGMENT) begin
            result.payload_offset = off_reg;
            result.fragment_size = fs;
            result.segment_length = {8'd0, job_reg.hlen} + fs;
            result.more_segments = !fin;
            result.zero_checksum = job_reg.zck;
            result.last = fin;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            if (result.last) begin
                busy_next = 1'b0;
            end
        end
        if (pop_valid && pop_ready) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            job_reg <= pop_job;
            left_reg <= pop_job.left;
            off_reg <= 16'd0;
        end else if (emit) begin
            left_reg <= left_reg - fs;
            off_reg <= off_reg + fs;
        end
        if (emit) begin
            out_reg <= result;
        end
    end

endmodule

/* rtl/core/datagram_fragment_planner.sv */
// top level of the datagram fragment planner
// results pass the front stage register, the job queue, and the back end's job and output registers
// throughput: one result per cycle while the output is taken; the back end loads a new job only
//   when idle, so the results of a datagram (n of them, n is at most 64) do not overlap the next
// the front accepts a request per cycle while the job queue has room
// reset (synchronous, aresetn low): queue and pipelines empty, id counter 0, mtu 1500
module datagram_fragment_planner import dfp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dfp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dfp_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] link_mtu_reg;
    logic        push_valid, push_ready;
    dfp_job_t    push_job;
    logic        pop_valid, pop_ready;
    dfp_job_t    pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mtu_reg <= LINK_MTU_RESET;
        end else if (cfg_wr_en) begin
            link_mtu_reg <= cfg_wr_data;
        end
    end

    dfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .link_mtu   (link_mtu_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    dfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    dfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
